[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/plcx_pkg.sv]
// ----------------------------------------------------------------------------
// plcx_pkg
// Constants, codes, types and helper functions of the PLC list executor.
// ----------------------------------------------------------------------------
package plcx_pkg;

    localparam int MARKER_BYTES   = 64;
    localparam int NUM_TIMERS     = 8;
    localparam int NUM_COUNTERS   = 8;
    localparam int NUM_DI_PINS    = 32;
    localparam int NUM_AO         = 12;
    localparam int AREA_FIELD_POS = 16;

    localparam int MB_AW = $clog2(MARKER_BYTES);
    localparam int TI_W  = $clog2(NUM_TIMERS);
    localparam int CI_W  = $clog2(NUM_COUNTERS);
    localparam int DI_W  = $clog2(NUM_DI_PINS);
    localparam int AO_W  = $clog2(NUM_AO);

    localparam logic [7:0] TICK_INC_RESET = 8'd10;
    localparam logic [7:0] MB1_RESET      = 8'h05;
    localparam logic       REG_TICK_INC   = 1'b0;

    // item kinds
    localparam logic [1:0] OP_EXEC = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_EOS  = 2'd2;

    // opcodes
    localparam logic [7:0] OPC_A    = 8'd1;
    localparam logic [7:0] OPC_O    = 8'd2;
    localparam logic [7:0] OPC_AN   = 8'd3;
    localparam logic [7:0] OPC_ON   = 8'd4;
    localparam logic [7:0] OPC_ASG  = 8'd5;
    localparam logic [7:0] OPC_S    = 8'd6;
    localparam logic [7:0] OPC_R    = 8'd7;
    localparam logic [7:0] OPC_FP   = 8'd8;
    localparam logic [7:0] OPC_FN   = 8'd9;
    localparam logic [7:0] OPC_L    = 8'd10;
    localparam logic [7:0] OPC_T    = 8'd11;
    localparam logic [7:0] OPC_SP   = 8'd12;
    localparam logic [7:0] OPC_SE   = 8'd13;
    localparam logic [7:0] OPC_SD   = 8'd14;
    localparam logic [7:0] OPC_SS   = 8'd15;
    localparam logic [7:0] OPC_SF   = 8'd16;
    localparam logic [7:0] OPC_RT   = 8'd17;
    localparam logic [7:0] OPC_CU   = 8'd18;
    localparam logic [7:0] OPC_CD   = 8'd19;
    localparam logic [7:0] OPC_CS   = 8'd20;
    localparam logic [7:0] OPC_CR   = 8'd21;
    localparam logic [7:0] OPC_CL   = 8'd22;
    localparam logic [7:0] OPC_ADD  = 8'd23;
    localparam logic [7:0] OPC_SUB  = 8'd24;
    localparam logic [7:0] OPC_MUL  = 8'd25;
    localparam logic [7:0] OPC_DIV  = 8'd26;
    localparam logic [7:0] OPC_EQ   = 8'd27;
    localparam logic [7:0] OPC_NE   = 8'd28;
    localparam logic [7:0] OPC_GT   = 8'd29;
    localparam logic [7:0] OPC_LT   = 8'd30;
    localparam logic [7:0] OPC_GE   = 8'd31;
    localparam logic [7:0] OPC_LE   = 8'd32;
    localparam logic [7:0] OPC_JU   = 8'd33;
    localparam logic [7:0] OPC_JC   = 8'd34;
    localparam logic [7:0] OPC_JCN  = 8'd35;

    // areas
    localparam logic [7:0] AR_DI    = 8'd1;
    localparam logic [7:0] AR_T     = 8'd2;
    localparam logic [7:0] AR_MBIT  = 8'd3;
    localparam logic [7:0] AR_DO    = 8'd4;
    localparam logic [7:0] AR_CONST = 8'd5;
    localparam logic [7:0] AR_AI    = 8'd6;
    localparam logic [7:0] AR_MB    = 8'd7;
    localparam logic [7:0] AR_MW    = 8'd8;
    localparam logic [7:0] AR_MD    = 8'd9;
    localparam logic [7:0] AR_AO    = 8'd10;
    localparam logic [7:0] AR_C     = 8'd11;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic       rd;
        logic       ex;
        logic [1:0] k;
        logic       mul;
        logic       div_start;
        logic       div_step;
        logic       fin;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] nbytes_m1;
        logic       is_mul;
        logic       is_div;
        logic       div_last;
    } stat_t;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic        div_by_zero;
        logic [7:0]  ao_value;
        logic [3:0]  ao_channel;
        logic        ao_write_valid;
        logic        do_value;
        logic [7:0]  do_pin;
        logic        do_write_valid;
        logic [7:0]  jump_target;
        logic        jump_taken;
        logic [31:0] accu_one;
        logic        rlo;
    } res_t;

    // clock-marker toggle intervals in ticks
    function automatic logic [7:0] clk_period(input int i);
        case (i)
            0: return 8'd10;
            1: return 8'd20;
            2: return 8'd40;
            3: return 8'd50;
            4: return 8'd80;
            5: return 8'd100;
            6: return 8'd160;
            default: return 8'd200;
        endcase
    endfunction

    // index modulo the analog-output count by compare and subtract
    function automatic logic [AO_W-1:0] ao_index(input logic [7:0] id);
        logic [15:0] r;
        r = {8'd0, id};
        for (int s = 7; s >= 0; s--) begin
            if (r >= (16'(NUM_AO) << s)) begin
                r = r - (16'(NUM_AO) << s);
            end
        end
        return r[AO_W-1:0];
    endfunction

endpackage

[rtl/plc_statement_list_executor.sv]
// ----------------------------------------------------------------------------
// plc_statement_list_executor
// Top level: APB register, sequencer, datapath and output word register.
// ----------------------------------------------------------------------------
// One word in, one result word out. A word passes the accept, marker read,
// execute and finish states on its way to the output register; word and dword
// loads and transfers repeat the read/execute pair per byte, since the marker
// memory moves one byte per pair. A multiply adds a multiply state, a divide
// the radix-2 divider steps. The next word is accepted once the previous
// one sits in the output register, even if it has not been taken. Marker
// memory entries carry valid bits, so no clearing pass follows reset.
module plc_statement_list_executor import plcx_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // instruction, di_pins, buttons_byte, analog_value
    input  logic [1:0]  s_tuser,  // op
    output logic        m_tvalid,
    input  logic        m_tready,
    // rlo, accu_one, jump_taken, jump_target, do_write_valid, do_pin,
    // do_value, ao_write_valid, ao_channel, ao_value, div_by_zero
    output logic [71:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t       cmd;
    stat_t      stat;
    res_t       res;
    res_t       out_reg;
    logic       m_valid_reg;
    logic       out_free;
    logic [7:0] tick_inc_reg;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TICK_INC) ? {24'd0, tick_inc_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_inc_reg <= TICK_INC_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TICK_INC)) begin
            tick_inc_reg <= pwdata[7:0];
        end
    end

    plcx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    plcx_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .tick_inc (tick_inc_reg),
        .stat     (stat),
        .res      (res)
    );

    // hold the result word until taken
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.fin) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

endmodule

[rtl/plcx_ctrl.sv]
// ----------------------------------------------------------------------------
// plcx_ctrl
// Sequencer: byte-serial read/execute steps, multiply, divide and finish.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plcx_ctrl import plcx_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  logic  out_free,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_EX   = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        cmd           = '0;
        cmd.k         = k_reg;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    k_next     = 2'd0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd     = 1'b1;
                state_next = ST_EX;
            end
            ST_EX: begin
                cmd.ex = 1'b1;
                if (k_reg != stat.nbytes_m1) begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_RD;
                end else if (stat.is_mul) begin
                    state_next = ST_MUL;
                end else if (stat.is_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_FIN;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= 2'd0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    `ASSERT_NEXT(a_rd_then_ex, aclk, aresetn, state_reg == ST_RD, state_reg == ST_EX, "read step not followed by execute")
    `ASSERT_IMPLY(a_k_range, aclk, aresetn, state_reg == ST_EX, k_reg <= stat.nbytes_m1, "byte step beyond access width")
    `ASSERT_NEXT(a_fin_hold, aclk, aresetn, state_reg == ST_FIN && !out_free, state_reg == ST_FIN, "result dropped while output full")

endmodule

[rtl/plcx_dp.sv]
// ----------------------------------------------------------------------------
// plcx_dp
// Datapath: item latch, marker memory, timers, counters, accumulators, divider.
// ----------------------------------------------------------------------------
module plcx_dp import plcx_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    input  logic [79:0] s_tdata,  // instruction, di_pins, buttons_byte, analog_value
    input  logic [1:0]  s_tuser,  // op
    input  logic [7:0]  tick_inc,
    output stat_t       stat,
    output res_t        res
);

    // latched item
    logic [1:0]  op_reg;
    logic [31:0] ins_reg, di_reg;
    logic [7:0]  btn_reg, ain_reg;

    logic [7:0] opc, area, id;
    logic [2:0] bsel;
    assign opc  = ins_reg[31:24];
    assign area = ins_reg[AREA_FIELD_POS +: 8];
    assign id   = ins_reg[11:4];
    assign bsel = ins_reg[2:0];

    // state
    logic [7:0]  mb0_reg, mb1_reg;
    logic [7:0]  mem [MARKER_BYTES];
    logic [MARKER_BYTES-1:0] mvld_reg;
    logic [7:0]  mem_q_reg;
    logic        vld_q_reg;
    logic [7:0]  ts_reg [NUM_TIMERS];
    logic [31:0] te_reg [NUM_TIMERS];
    logic [31:0] cnt_reg [NUM_COUNTERS];
    logic [7:0]  pre_reg [8];
    logic [7:0]  ao_reg [NUM_AO];
    logic [7:0]  cs_reg;
    logic [31:0] acc0_reg, acc1_reg, ld_tmp_reg;
    logic        rlo_reg, fc_reg;

    // per-item result flags
    logic       jt_reg, dov_reg, doval_reg, aov_reg, dz_reg;
    logic [7:0] jtgt_reg, dopin_reg, aoval_reg;
    logic [3:0] aoch_reg;

    // divider
    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic        neg_reg;
    logic [4:0]  dcnt_reg;

    // addressing
    logic [9:0]       mlin;
    logic [MB_AW-1:0] midx;
    logic [TI_W-1:0]  tidx;
    logic [CI_W-1:0]  cidx;
    logic [AO_W-1:0]  aidx;
    logic             area_marker;

    assign area_marker = (area == AR_MBIT) || (area == AR_MB) ||
                         (area == AR_MW) || (area == AR_MD);
    assign tidx = id[TI_W-1:0];
    assign cidx = id[CI_W-1:0];
    assign aidx = ao_index(id);

    // scale the index by the access width only for multi-byte loads and transfers
    always_comb begin
        case (stat.nbytes_m1)
            2'd1:    mlin = {1'b0, id, 1'b0} | {8'd0, cmd.k};
            2'd3:    mlin = {id, 2'b00} | {8'd0, cmd.k};
            default: mlin = {2'b00, id};
        endcase
    end
    assign midx = mlin[MB_AW-1:0];

    // byte and bit read
    logic [7:0] byte_val;
    logic       bit_val;
    always_comb begin
        if (area_marker) begin
            if (midx == MB_AW'(0))      byte_val = mb0_reg;
            else if (midx == MB_AW'(1)) byte_val = mb1_reg;
            else if (midx == MB_AW'(2)) byte_val = btn_reg;
            else                        byte_val = vld_q_reg ? mem_q_reg : 8'd0;
        end else begin
            case (area)
                AR_T:    byte_val = ts_reg[tidx];
                AR_AI:   byte_val = ain_reg;
                AR_AO:   byte_val = ao_reg[aidx];
                AR_C:    byte_val = cs_reg;
                default: byte_val = 8'd0;
            endcase
        end
    end
    assign bit_val = (area == AR_DI) ? di_reg[id[DI_W-1:0]] : byte_val[bsel];

    // execute step
    logic        last;
    logic        rlo_next, fc_next;
    logic [31:0] acc0_next, acc1_next, ld_tmp_next;
    logic        bwr_en, dow_en, dow_val, bit_we, bit_wv, lvl, bv;
    logic [7:0]  bwr_val, tstat;
    logic        te_clr, te_gt, cnt_we, jt_set, dz_set;
    logic [31:0] cnt_val;
    logic [7:0]  bmask;

    assign last  = (cmd.k == stat.nbytes_m1);
    assign te_gt = te_reg[tidx] > acc0_reg;
    assign bmask = 8'd1 << bsel;
    assign ld_tmp_next = ld_tmp_reg | (32'(byte_val) << {cmd.k, 3'b000});

    always_comb begin
        rlo_next  = rlo_reg;
        fc_next   = fc_reg;
        acc0_next = acc0_reg;
        acc1_next = acc1_reg;
        bwr_en    = 1'b0;
        bwr_val   = byte_val;
        dow_en    = 1'b0;
        dow_val   = 1'b0;
        bit_we    = 1'b0;
        bit_wv    = 1'b0;
        lvl       = 1'b0;
        bv        = 1'b0;
        tstat     = byte_val;
        te_clr    = 1'b0;
        cnt_we    = 1'b0;
        cnt_val   = cnt_reg[cidx];
        jt_set    = 1'b0;
        dz_set    = 1'b0;
        if (op_reg == OP_EXEC) begin
            case (opc)
                OPC_A, OPC_O, OPC_AN, OPC_ON: begin
                    bv = bit_val ^ ((opc == OPC_AN) || (opc == OPC_ON));
                    if (fc_reg) rlo_next = bv;
                    else if ((opc == OPC_A) || (opc == OPC_AN)) rlo_next = rlo_reg & bv;
                    else rlo_next = rlo_reg | bv;
                    fc_next = 1'b0;
                end
                OPC_ASG: begin
                    bit_we  = 1'b1;
                    bit_wv  = rlo_reg;
                    fc_next = 1'b1;
                end
                OPC_S, OPC_R: begin
                    bit_we  = rlo_reg;
                    bit_wv  = (opc == OPC_S);
                    fc_next = 1'b1;
                end
                OPC_FP, OPC_FN: begin
                    lvl      = (opc == OPC_FP);
                    bit_we   = !((rlo_reg == lvl) && (bit_val == lvl));
                    bit_wv   = rlo_reg;
                    rlo_next = (rlo_reg == lvl) && (bit_val != lvl);
                    fc_next  = 1'b0;
                end
                OPC_L: begin
                    if (last) begin
                        acc1_next = acc0_reg;
                        acc0_next = (area == AR_CONST) ? {16'd0, ins_reg[15:0]} : ld_tmp_next;
                    end
                end
                OPC_T: begin
                    bwr_en  = 1'b1;
                    bwr_val = acc0_reg[{cmd.k, 3'b000} +: 8];
                    if (last) begin
                        acc0_next = acc1_reg;
                        acc1_next = 32'd0;
                    end
                end
                OPC_SP: begin
                    if (rlo_reg) begin
                        if (!tstat[1]) begin tstat = 8'd3; te_clr = 1'b1; end
                        if (!te_clr && te_gt && tstat[1]) tstat[0] = 1'b0;
                    end else tstat[1:0] = 2'b00;
                    fc_next = 1'b1;
                end
                OPC_SE: begin
                    if (rlo_reg && !tstat[1]) begin tstat = 8'd3; te_clr = 1'b1; end
                    if (!te_clr && te_gt && tstat[1]) tstat[1:0] = 2'b00;
                    fc_next = 1'b1;
                end
                OPC_SD: begin
                    if (rlo_reg) begin
                        if (!tstat[1]) begin tstat = 8'd2; te_clr = 1'b1; end
                        if (!te_clr && te_gt && tstat[1]) tstat[0] = 1'b1;
                    end else tstat[1:0] = 2'b00;
                    fc_next = 1'b1;
                end
                OPC_SS: begin
                    if (rlo_reg && !tstat[1]) begin tstat = 8'd2; te_clr = 1'b1; end
                    if (!te_clr && te_gt && tstat[1]) tstat[0] = 1'b1;
                    fc_next = 1'b1;
                end
                OPC_SF: begin
                    if (rlo_reg) begin
                        if (!tstat[1]) tstat[0] = 1'b1;
                    end else begin
                        if (tstat[1:0] == 2'b01) begin tstat[1:0] = 2'b11; te_clr = 1'b1; end
                        if (!te_clr && te_gt && tstat[1]) tstat[1:0] = 2'b00;
                    end
                    fc_next = 1'b1;
                end
                OPC_RT: begin
                    if (rlo_reg) tstat[1:0] = 2'b00;
                    fc_next = 1'b1;
                end
                OPC_CU, OPC_CD, OPC_CS, OPC_CR: begin
                    cnt_we = rlo_reg;
                    case (opc)
                        OPC_CU:  cnt_val = cnt_reg[cidx] + 32'd1;
                        OPC_CD:  cnt_val = cnt_reg[cidx] - 32'd1;
                        OPC_CS:  cnt_val = acc0_reg;
                        default: cnt_val = 32'd0;
                    endcase
                    fc_next = 1'b1;
                end
                OPC_CL: begin
                    acc1_next = acc0_reg;
                    acc0_next = cnt_reg[cidx];
                end
                OPC_ADD: acc0_next = acc1_reg + acc0_reg;
                OPC_SUB: acc0_next = acc1_reg - acc0_reg;
                OPC_DIV: begin
                    if (acc0_reg == 32'd0) dz_set = 1'b1;
                end
                OPC_EQ, OPC_NE, OPC_GT, OPC_LT, OPC_GE, OPC_LE: begin
                    case (opc)
                        OPC_EQ:  rlo_next = acc1_reg == acc0_reg;
                        OPC_NE:  rlo_next = acc1_reg != acc0_reg;
                        OPC_GT:  rlo_next = $signed(acc1_reg) > $signed(acc0_reg);
                        OPC_LT:  rlo_next = $signed(acc1_reg) < $signed(acc0_reg);
                        OPC_GE:  rlo_next = $signed(acc1_reg) >= $signed(acc0_reg);
                        default: rlo_next = $signed(acc1_reg) <= $signed(acc0_reg);
                    endcase
                    fc_next = 1'b0;
                end
                OPC_JU, OPC_JC, OPC_JCN: begin
                    jt_set = (opc == OPC_JU) || ((opc == OPC_JC) && rlo_reg) ||
                             ((opc == OPC_JCN) && !rlo_reg);
                    if (opc != OPC_JU) fc_next = 1'b1;
                end
                default: begin
                end
            endcase
            // timer status write back when changed
            if ((opc >= OPC_SP) && (opc <= OPC_RT)) begin
                bwr_en  = tstat != byte_val;
                bwr_val = tstat;
            end
            // bit write: pin report or read-modify-write of the byte
            if (bit_we) begin
                if (area == AR_DO) begin
                    dow_en  = 1'b1;
                    dow_val = bit_wv;
                end else begin
                    bwr_en  = 1'b1;
                    bwr_val = (byte_val & ~bmask) | (bit_wv ? bmask : 8'd0);
                end
            end
        end else if (op_reg == OP_EOS) begin
            acc0_next = 32'd0;
            acc1_next = 32'd0;
            rlo_next  = 1'b0;
            fc_next   = 1'b1;
        end
    end

    logic mem_we;
    assign mem_we = cmd.ex && bwr_en && area_marker && (midx > MB_AW'(2));

    // divider step
    logic [32:0] rtry, rsub;
    logic        dge;
    logic [31:0] qfin, a1_abs, a0_abs;
    assign rtry   = {rem_reg, quo_reg[31]};
    assign dge    = rtry >= {1'b0, dvs_reg};
    assign rsub   = rtry - {1'b0, dvs_reg};
    assign qfin   = {quo_reg[30:0], dge};
    assign a1_abs = acc1_reg[31] ? -acc1_reg : acc1_reg;
    assign a0_abs = acc0_reg[31] ? -acc0_reg : acc0_reg;

    logic [31:0] prod;
    assign prod = acc1_reg * acc0_reg;

    // latch item, marker memory, divider data
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg  <= s_tuser;
            ins_reg <= s_tdata[31:0];
            di_reg  <= s_tdata[63:32];
            btn_reg <= s_tdata[71:64];
            ain_reg <= s_tdata[79:72];
        end
        if (cmd.rd) begin
            mem_q_reg <= mem[midx];
            vld_q_reg <= mvld_reg[midx];
        end
        if (mem_we) begin
            mem[midx] <= bwr_val;
        end
        if (cmd.div_start) begin
            rem_reg  <= 32'd0;
            quo_reg  <= a1_abs;
            dvs_reg  <= a0_abs;
            neg_reg  <= acc1_reg[31] ^ acc0_reg[31];
        end else if (cmd.div_step) begin
            rem_reg <= dge ? rsub[31:0] : rtry[31:0];
            quo_reg <= qfin;
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mb0_reg    <= 8'd0;
            mb1_reg    <= MB1_RESET;
            mvld_reg   <= '0;
            cs_reg     <= 8'd0;
            acc0_reg   <= 32'd0;
            acc1_reg   <= 32'd0;
            rlo_reg    <= 1'b1;
            fc_reg     <= 1'b1;
            dcnt_reg   <= 5'd0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                ts_reg[i] <= 8'd0;
                te_reg[i] <= 32'd0;
            end
            for (int i = 0; i < NUM_COUNTERS; i++) cnt_reg[i] <= 32'd0;
            for (int i = 0; i < 8; i++) pre_reg[i] <= 8'd0;
            for (int i = 0; i < NUM_AO; i++) ao_reg[i] <= 8'd0;
        end else begin
            if (cmd.ex) begin
                rlo_reg  <= rlo_next;
                fc_reg   <= fc_next;
                acc0_reg <= acc0_next;
                acc1_reg <= acc1_next;
                if (op_reg == OP_TICK) begin
                    // advance timers and clock-marker prescalers
                    for (int i = 0; i < NUM_TIMERS; i++) te_reg[i] <= te_reg[i] + 32'(tick_inc);
                    for (int i = 0; i < 8; i++) begin
                        if (pre_reg[i] + 8'd1 >= clk_period(i)) begin
                            pre_reg[i] <= 8'd0;
                            mb0_reg[i] <= ~mb0_reg[i];
                        end else begin
                            pre_reg[i] <= pre_reg[i] + 8'd1;
                        end
                    end
                end else if (op_reg == OP_EOS) begin
                    mb1_reg[0] <= 1'b0;
                end
                if (te_clr) te_reg[tidx] <= 32'd0;
                if (cnt_we) cnt_reg[cidx] <= cnt_val;
                if (bwr_en) begin
                    if (area_marker) begin
                        if (midx == MB_AW'(0)) mb0_reg <= bwr_val;
                        else if (midx == MB_AW'(1)) mb1_reg <= bwr_val;
                        else if (midx != MB_AW'(2)) mvld_reg[midx] <= 1'b1;
                    end else begin
                        case (area)
                            AR_T:    ts_reg[tidx] <= bwr_val;
                            AR_AO:   ao_reg[aidx] <= bwr_val;
                            AR_C:    cs_reg <= bwr_val;
                            default: begin
                            end
                        endcase
                    end
                end
            end
            if (cmd.mul) acc0_reg <= prod;
            if (cmd.div_start) begin
                dcnt_reg <= 5'd0;
            end else if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg + 5'd1;
                if (stat.div_last) acc0_reg <= neg_reg ? -qfin : qfin;
            end
        end
    end

    // per-item report fields
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            jt_reg    <= 1'b0;
            jtgt_reg  <= 8'd0;
            dov_reg   <= 1'b0;
            dopin_reg <= 8'd0;
            doval_reg <= 1'b0;
            aov_reg   <= 1'b0;
            aoch_reg  <= 4'd0;
            aoval_reg <= 8'd0;
            dz_reg    <= 1'b0;
            ld_tmp_reg <= 32'd0;
        end else if (cmd.ex) begin
            ld_tmp_reg <= ld_tmp_next;
            if (jt_set) begin
                jt_reg   <= 1'b1;
                jtgt_reg <= ins_reg[7:0];
            end
            if (dz_set) dz_reg <= 1'b1;
            if (dow_en) begin
                dov_reg   <= 1'b1;
                dopin_reg <= id;
                doval_reg <= dow_val;
            end
            if (bwr_en && !area_marker && (area == AR_AO)) begin
                aov_reg   <= 1'b1;
                aoch_reg  <= 4'(aidx);
                aoval_reg <= bwr_val;
            end
        end
    end

    // status
    always_comb begin
        stat.nbytes_m1 = 2'd0;
        if ((op_reg == OP_EXEC) && ((opc == OPC_L) || (opc == OPC_T))) begin
            if (area == AR_MW) stat.nbytes_m1 = 2'd1;
            else if (area == AR_MD) stat.nbytes_m1 = 2'd3;
        end
        stat.is_mul   = (op_reg == OP_EXEC) && (opc == OPC_MUL);
        stat.is_div   = (op_reg == OP_EXEC) && (opc == OPC_DIV) && (acc0_reg != 32'd0);
        stat.div_last = dcnt_reg == 5'd31;
    end

    assign res.div_by_zero    = dz_reg;
    assign res.ao_value       = aoval_reg;
    assign res.ao_channel     = aoch_reg;
    assign res.ao_write_valid = aov_reg;
    assign res.do_value       = doval_reg;
    assign res.do_pin         = dopin_reg;
    assign res.do_write_valid = dov_reg;
    assign res.jump_target    = jtgt_reg;
    assign res.jump_taken     = jt_reg;
    assign res.accu_one       = acc0_reg;
    assign res.rlo            = rlo_reg;

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PLC list executor. A directed table covers
// reset values, accumulator extremes, divide by zero, the signed overflow
// divide, wrapped indices, unknown opcodes and the scan items. Random
// instruction streams follow over three tick settings and idle patterns.
// Every result word is checked against an in-bench execution model.
// ----------------------------------------------------------------------------
module tb_top;
    import plcx_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [2:0] ADDR_TICK_INC = 3'd0;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // instruction, di_pins, buttons_byte, analog_value
    logic [1:0]  s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    // rlo, accu_one, jump_taken, jump_target, do_write_valid, do_pin,
    // do_value, ao_write_valid, ao_channel, ao_value, div_by_zero
    logic [71:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    plc_statement_list_executor dut (.*);

    typedef struct {
        res_t        word;
        bit          fixed;
        logic        rlo;
        logic [31:0] accu;
        logic        dz;
    } expect_entry_t;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] ins;
        bit          fixed;
        logic        rlo;
        logic [31:0] accu;
        logic        dz;
    } row_t;

    expect_entry_t result_queue[$];
    row_t          directed_rows[$];

    int  cycles;
    int  errors;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  long_hold_req;

    // execution model state
    logic [7:0]  mk[MARKER_BYTES];
    logic [7:0]  tst[NUM_TIMERS];
    logic [7:0]  cst;
    logic [31:0] tel[NUM_TIMERS];
    logic [31:0] cnt[NUM_COUNTERS];
    logic [7:0]  pres[8];
    logic [31:0] acc0, acc1;
    logic        rlo_q, first_chk;
    logic [7:0]  aov[NUM_AO];
    logic [7:0]  tick_inc;
    logic [31:0] cur_di;
    logic [7:0]  cur_btn, cur_ai;
    res_t        outw;

    // clock and cycle watchdog
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void model_reset();
        for (int i = 0; i < MARKER_BYTES; i++) mk[i] = 8'h00;
        mk[1] = MB1_RESET;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            tst[i] = 8'h00;
            tel[i] = 32'h0;
        end
        for (int i = 0; i < NUM_COUNTERS; i++) cnt[i] = 32'h0;
        for (int i = 0; i < 8; i++) pres[i] = 8'h00;
        for (int i = 0; i < NUM_AO; i++) aov[i] = 8'h00;
        cst = 8'h00;
        acc0 = 32'h0;
        acc1 = 32'h0;
        rlo_q = 1'b1;
        first_chk = 1'b1;
        tick_inc = TICK_INC_RESET;
    endfunction

    function automatic logic [7:0] store_rd(logic [7:0] area, int id);
        int k;
        case (area)
            AR_MBIT, AR_MB, AR_MW, AR_MD: begin
                k = id % MARKER_BYTES;
                return (k == 2) ? cur_btn : mk[k];
            end
            AR_T:  return tst[id % NUM_TIMERS];
            AR_AI: return cur_ai;
            AR_AO: return aov[id % NUM_AO];
            AR_C:  return cst;
            default: return 8'h00;
        endcase
    endfunction

    function automatic void store_wr(logic [7:0] area, int id, logic [7:0] v);
        int k;
        case (area)
            AR_MBIT, AR_MB, AR_MW, AR_MD: begin
                k = id % MARKER_BYTES;
                if (k != 2) mk[k] = v;
            end
            AR_T: tst[id % NUM_TIMERS] = v;
            AR_AO: begin
                k = id % NUM_AO;
                aov[k] = v;
                outw.ao_write_valid = 1'b1;
                outw.ao_channel = 4'(k);
                outw.ao_value = v;
            end
            AR_C: cst = v;
            default: ;
        endcase
    endfunction

    function automatic logic bit_rd(logic [7:0] area, int id, int b);
        logic [7:0] v;
        if (area == AR_DI) return cur_di[id % NUM_DI_PINS];
        v = store_rd(area, id);
        return v[b];
    endfunction

    function automatic void bit_wr(logic [7:0] area, int id, int b, logic v);
        logic [7:0] old;
        if (area == AR_DO) begin
            outw.do_write_valid = 1'b1;
            outw.do_pin = 8'(id);
            outw.do_value = v;
        end else begin
            old = store_rd(area, id);
            old[b] = v;
            store_wr(area, id, old);
        end
    endfunction

    // timer status: bit 1 running, bit 0 output
    function automatic void timer_exec(logic [7:0] opc, logic [7:0] area, int id);
        int ti;
        logic [7:0] s, s0;
        logic expired;
        ti = id % NUM_TIMERS;
        s = store_rd(area, id);
        s0 = s;
        case (opc)
            OPC_SP: begin
                if (rlo_q) begin
                    if (!s[1]) begin s = 8'd3; tel[ti] = 0; end
                    if (tel[ti] > acc0 && s[1]) s[0] = 1'b0;
                end else s[1:0] = 2'b00;
            end
            OPC_SE: begin
                if (rlo_q && !s[1]) begin s = 8'd3; tel[ti] = 0; end
                if (tel[ti] > acc0 && s[1]) s[1:0] = 2'b00;
            end
            OPC_SD: begin
                if (rlo_q) begin
                    if (!s[1]) begin s = 8'd2; tel[ti] = 0; end
                    if (tel[ti] > acc0 && s[1]) s[0] = 1'b1;
                end else s[1:0] = 2'b00;
            end
            OPC_SS: begin
                if (rlo_q && !s[1]) begin s = 8'd2; tel[ti] = 0; end
                if (tel[ti] > acc0 && s[1]) s[0] = 1'b1;
            end
            OPC_SF: begin
                if (rlo_q) begin
                    if (!s[1]) s[0] = 1'b1;
                end else begin
                    if (s[1:0] == 2'b01) begin s[1:0] = 2'b11; tel[ti] = 0; end
                    expired = tel[ti] > acc0;
                    if (expired && s[1]) s[1:0] = 2'b00;
                end
            end
            default: if (rlo_q) s[1:0] = 2'b00;
        endcase
        if (s != s0) store_wr(area, id, s);
        first_chk = 1'b1;
    endfunction

    function automatic res_t predict_word(logic [1:0] op, logic [31:0] ins,
                                          logic [31:0] di, logic [7:0] btn,
                                          logic [7:0] ai);
        logic [7:0] opc, area, id;
        int b, w;
        logic v, m, lvl;
        logic [31:0] x32;
        int sx, sy;
        opc = ins[31:24];
        area = ins[AREA_FIELD_POS +: 8];
        id = ins[11:4];
        b = ins[2:0];
        cur_di = di;
        cur_btn = btn;
        cur_ai = ai;
        outw = '0;
        if (op == OP_TICK) begin
            for (int i = 0; i < NUM_TIMERS; i++) tel[i] = tel[i] + tick_inc;
            for (int i = 0; i < 8; i++) begin
                pres[i] = pres[i] + 1;
                if (pres[i] >= clk_period(i)) begin
                    pres[i] = 0;
                    mk[0][i] = ~mk[0][i];
                end
            end
        end else if (op == OP_EOS) begin
            mk[1][0] = 1'b0;
            acc0 = 0;
            acc1 = 0;
            rlo_q = 1'b0;
            first_chk = 1'b1;
        end else if (op == OP_EXEC) begin
            case (opc)
                OPC_A, OPC_O, OPC_AN, OPC_ON: begin
                    v = bit_rd(area, id, b);
                    if (opc == OPC_AN || opc == OPC_ON) v = ~v;
                    if (first_chk) rlo_q = v;
                    else if (opc == OPC_A || opc == OPC_AN) rlo_q = rlo_q & v;
                    else rlo_q = rlo_q | v;
                    first_chk = 1'b0;
                end
                OPC_ASG: begin
                    bit_wr(area, id, b, rlo_q);
                    first_chk = 1'b1;
                end
                OPC_S, OPC_R: begin
                    if (rlo_q) bit_wr(area, id, b, opc == OPC_S);
                    first_chk = 1'b1;
                end
                OPC_FP, OPC_FN: begin
                    m = bit_rd(area, id, b);
                    lvl = (opc == OPC_FP);
                    if (rlo_q != lvl) bit_wr(area, id, b, ~lvl);
                    if (rlo_q == lvl && m != lvl) begin
                        rlo_q = 1'b1;
                        bit_wr(area, id, b, lvl);
                    end else rlo_q = 1'b0;
                    first_chk = 1'b0;
                end
                OPC_L: begin
                    x32 = 0;
                    if (area == AR_CONST) x32 = {16'h0, ins[15:0]};
                    else if (area == AR_AI) x32 = {24'h0, ai};
                    else begin
                        w = (area == AR_MW) ? 2 : (area == AR_MD) ? 4 : 1;
                        for (int k = 0; k < w; k++)
                            x32[k*8 +: 8] = store_rd(area, id * w + k);
                    end
                    acc1 = acc0;
                    acc0 = x32;
                end
                OPC_T: begin
                    x32 = acc0;
                    acc0 = acc1;
                    acc1 = 0;
                    w = (area == AR_MW) ? 2 : (area == AR_MD) ? 4 : 1;
                    for (int k = 0; k < w; k++) store_wr(area, id * w + k, x32[k*8 +: 8]);
                end
                OPC_SP, OPC_SE, OPC_SD, OPC_SS, OPC_SF, OPC_RT: timer_exec(opc, area, id);
                OPC_CU, OPC_CD, OPC_CS, OPC_CR: begin
                    if (rlo_q) begin
                        case (opc)
                            OPC_CU: cnt[id % NUM_COUNTERS] = cnt[id % NUM_COUNTERS] + 1;
                            OPC_CD: cnt[id % NUM_COUNTERS] = cnt[id % NUM_COUNTERS] - 1;
                            OPC_CS: cnt[id % NUM_COUNTERS] = acc0;
                            default: cnt[id % NUM_COUNTERS] = 0;
                        endcase
                    end
                    first_chk = 1'b1;
                end
                OPC_CL: begin
                    acc1 = acc0;
                    acc0 = cnt[id % NUM_COUNTERS];
                end
                OPC_ADD: acc0 = acc1 + acc0;
                OPC_SUB: acc0 = acc1 - acc0;
                OPC_MUL: acc0 = acc1 * acc0;
                OPC_DIV: begin
                    if (acc0 == 0) begin
                        acc0 = 0;
                        outw.div_by_zero = 1'b1;
                    end else if (acc1 == 32'h8000_0000 && acc0 == 32'hFFFF_FFFF) begin
                        acc0 = 32'h8000_0000;
                    end else begin
                        sx = acc1;
                        sy = acc0;
                        acc0 = sx / sy;
                    end
                end
                OPC_EQ, OPC_NE, OPC_GT, OPC_LT, OPC_GE, OPC_LE: begin
                    sx = acc1;
                    sy = acc0;
                    case (opc)
                        OPC_EQ: rlo_q = sx == sy;
                        OPC_NE: rlo_q = sx != sy;
                        OPC_GT: rlo_q = sx > sy;
                        OPC_LT: rlo_q = sx < sy;
                        OPC_GE: rlo_q = sx >= sy;
                        default: rlo_q = sx <= sy;
                    endcase
                    first_chk = 1'b0;
                end
                OPC_JU, OPC_JC, OPC_JCN: begin
                    if (opc == OPC_JU || (opc == OPC_JC && rlo_q) ||
                        (opc == OPC_JCN && !rlo_q)) begin
                        outw.jump_taken = 1'b1;
                        outw.jump_target = ins[7:0];
                    end
                    if (opc != OPC_JU) first_chk = 1'b1;
                end
                default: ;
            endcase
        end
        outw.rlo = rlo_q;
        outw.accu_one = acc0;
        return outw;
    endfunction

    function automatic logic [31:0] ins_bit(logic [7:0] opc, logic [7:0] area,
                                            logic [7:0] id, logic [2:0] b);
        return {opc, area, 4'h0, id, 1'b0, b};
    endfunction

    function automatic void add_row(logic [1:0] op, logic [31:0] ins, bit fixed,
                                    logic rlo, logic [31:0] accu, logic dz);
        row_t r;
        r.op = op;
        r.ins = ins;
        r.fixed = fixed;
        r.rlo = rlo;
        r.accu = accu;
        r.dz = dz;
        directed_rows.push_back(r);
    endfunction

    // offer one word, wait for acceptance, then record its expected result
    task automatic send_word(logic [1:0] op, logic [31:0] ins, bit fixed,
                             logic rlo, logic [31:0] accu, logic dz);
        logic [31:0] di;
        logic [7:0] btn, ai;
        expect_entry_t e;
        di = $urandom;
        btn = 8'($urandom);
        ai = 8'($urandom);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ai, btn, di, ins};
        s_tuser <= op;
        do @(posedge aclk); while (!s_tready);
        e.word = predict_word(op, ins, di, btn, ai);
        e.fixed = fixed;
        e.rlo = rlo;
        e.accu = accu;
        e.dz = dz;
        result_queue.push_back(e);
        @(negedge aclk);
    endtask

    task automatic send_random();
        logic [1:0] op;
        logic [7:0] opc, area, id;
        logic [31:0] ins;
        int r;
        r = $urandom_range(99);
        op = (r < 82) ? OP_EXEC : (r < 91) ? OP_TICK : (r < 97) ? OP_EOS : OP_NONE;
        opc = ($urandom_range(9) != 0) ? 8'($urandom_range(35)) : 8'($urandom);
        area = ($urandom_range(6) != 0) ? 8'($urandom_range(12)) : 8'($urandom);
        id = ($urandom_range(3) != 0) ? 8'($urandom_range(15)) : 8'($urandom);
        ins = {opc, area, 4'($urandom), id, 1'($urandom), 3'($urandom)};
        if ($urandom_range(19) == 0) ins = $urandom;
        send_word(op, ins, 1'b0, 1'b0, 32'h0, 1'b0);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_TICK_INC) tick_inc = data[7:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (result_queue.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    function automatic void check_field(string name, logic [31:0] exp_v,
                                        logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endfunction

    // result word checker
    always @(posedge aclk) begin
        res_t got;
        expect_entry_t e;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[$bits(res_t)-1:0]);
            if (result_queue.size() == 0) begin
                errors++;
                $display("%0t unexpected result word %h", $time, m_tdata);
            end else begin
                e = result_queue.pop_front();
                check_field("rlo", e.word.rlo, got.rlo);
                check_field("accu_one", e.word.accu_one, got.accu_one);
                check_field("jump_taken", e.word.jump_taken, got.jump_taken);
                check_field("jump_target", e.word.jump_target, got.jump_target);
                check_field("do_write_valid", e.word.do_write_valid, got.do_write_valid);
                check_field("do_pin", e.word.do_pin, got.do_pin);
                check_field("do_value", e.word.do_value, got.do_value);
                check_field("ao_write_valid", e.word.ao_write_valid, got.ao_write_valid);
                check_field("ao_channel", e.word.ao_channel, got.ao_channel);
                check_field("ao_value", e.word.ao_value, got.ao_value);
                check_field("div_by_zero", e.word.div_by_zero, got.div_by_zero);
                if (e.fixed) begin
                    check_field("table rlo", e.rlo, got.rlo);
                    check_field("table accu_one", e.accu, got.accu_one);
                    check_field("table div_by_zero", e.dz, got.div_by_zero);
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                long_hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // main sequence
    initial begin
        cycles = 0;
        errors = 0;
        long_hold_req = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_EXEC;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 23;
        recv_idle_pct = 77;
        model_reset();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed table: reset values, accumulator extremes, special cases
        add_row(OP_EXEC, 32'h0, 1, 1'b1, 32'h0, 1'b0);
        add_row(OP_EXEC, {OPC_L, AR_CONST, 16'hFFFF}, 1, 1'b1, 32'hFFFF, 1'b0);
        add_row(OP_EXEC, {OPC_L, AR_CONST, 16'h0000}, 1, 1'b1, 32'h0, 1'b0);
        add_row(OP_EXEC, {OPC_DIV, 24'h0}, 1, 1'b1, 32'h0, 1'b1);
        add_row(OP_EXEC, {OPC_L, AR_CONST, 16'h8000}, 0, 0, 0, 0);
        add_row(OP_EXEC, {OPC_L, AR_CONST, 16'h8000}, 0, 0, 0, 0);
        add_row(OP_EXEC, {OPC_MUL, 24'h0}, 1, 1'b1, 32'h4000_0000, 1'b0);
        add_row(OP_EXEC, ins_bit(OPC_T, AR_MD, 8'd1, 3'd0), 0, 0, 0, 0);
        add_row(OP_EXEC, ins_bit(OPC_L, AR_MD, 8'd1, 3'd0), 0, 0, 0, 0);
        add_row(OP_EXEC, ins_bit(OPC_L, AR_MD, 8'd1, 3'd0), 0, 0, 0, 0);
        add_row(OP_EXEC, {OPC_ADD, 24'h0}, 1, 1'b1, 32'h8000_0000, 1'b0);
        add_row(OP_EXEC, ins_bit(OPC_T, AR_MD, 8'd2, 3'd0), 0, 0, 0, 0);
        add_row(OP_EXEC, {OPC_L, AR_CONST, 16'h0000}, 0, 0, 0, 0);
        add_row(OP_EXEC, {OPC_L, AR_CONST, 16'h0001}, 0, 0, 0, 0);
        add_row(OP_EXEC, {OPC_SUB, 24'h0}, 1, 1'b1, 32'hFFFF_FFFF, 1'b0);
        add_row(OP_EXEC, ins_bit(OPC_T, AR_MD, 8'd3, 3'd0), 0, 0, 0, 0);
        add_row(OP_EXEC, ins_bit(OPC_L, AR_MD, 8'd2, 3'd0), 0, 0, 0, 0);
        add_row(OP_EXEC, ins_bit(OPC_L, AR_MD, 8'd3, 3'd0), 0, 0, 0, 0);
        add_row(OP_EXEC, {OPC_DIV, 24'h0}, 1, 1'b1, 32'h8000_0000, 1'b0);
        add_row(OP_EXEC, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_row(OP_NONE, ins_bit(OPC_CU, AR_C, 8'd3, 3'd1), 0, 0, 0, 0);
        add_row(OP_EXEC, ins_bit(OPC_T, AR_AO, 8'hFF, 3'd0), 0, 0, 0, 0);
        add_row(OP_EXEC, ins_bit(OPC_ASG, AR_DO, 8'hFF, 3'd7), 0, 0, 0, 0);
        add_row(OP_EXEC, ins_bit(OPC_A, AR_DI, 8'hFF, 3'd7), 0, 0, 0, 0);
        add_row(OP_EXEC, {OPC_JU, 16'h0, 8'hFF}, 0, 0, 0, 0);
        add_row(OP_TICK, 32'h0, 0, 0, 0, 0);
        add_row(OP_EOS, 32'h0, 1, 1'b0, 32'h0, 1'b0);
        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].ins, directed_rows[i].fixed,
                      directed_rows[i].rlo, directed_rows[i].accu, directed_rows[i].dz);
        drain();

        // random phase one: smallest tick step
        write_reg(ADDR_TICK_INC, 32'd1);
        repeat (140) send_random();
        drain();

        // random phase two: largest tick step, idle roles swapped
        send_idle_pct = 77;
        recv_idle_pct = 23;
        write_reg(ADDR_TICK_INC, 32'd255);
        repeat (140) send_random();
        drain();

        // random phase three: no idling, one long receiver hold
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(ADDR_TICK_INC, 32'd37);
        long_hold_req = 1'b1;
        repeat (150) send_random();
        drain();

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
